### src/wtd_pkg.sv
// Shared types, widths and codes of the wavelet transient detector.
package wtd_pkg;

   // Array sizes and field widths.
   localparam int MAX_TAPS     = 128;
   localparam int MAX_SCALES   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int COEF_BITS    = 16;
   localparam int TAP_W        = 7;
   localparam int SCALE_W      = 4;
   localparam int COEF_ADDR_W  = SCALE_W + TAP_W;
   localparam int COEF_DEPTH   = MAX_SCALES * MAX_TAPS;
   localparam int ACTIVE_W     = 5;
   localparam int MODE_W       = 2;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 5;

   // Arithmetic widths.
   localparam int PROD_W       = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W        = PROD_W + TAP_W;
   localparam int MAG_W        = 35;
   localparam int HALF_W       = 18;
   localparam int SQ_W         = 72;
   localparam int ENERGY_W     = 42;
   localparam int SCORE_W      = 24;
   localparam int NUM_W        = ENERGY_W + 16;
   localparam int DEN_W        = ENERGY_W + 1;
   localparam int TOTAL_W      = 51;

   // Epsilon of 1e-6 in Q10.32.
   localparam logic [DEN_W-1:0] EPS_Q = DEN_W'(4295);
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1);

   // Input item modes.
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SCALES = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_SCALE  = 4'd1;

   typedef enum logic [1:0] {
      CMD_SAMPLE,
      CMD_LOAD,
      CMD_CLEAR
   } cmd_kind_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      cmd_kind_type                  kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [COEF_ADDR_W-1:0]        coef_addr;
      logic signed [COEF_BITS-1:0]   coef_real;
      logic signed [COEF_BITS-1:0]   coef_imag;
   } cmd_type;

   // Configuration as the back end sees it.
   typedef struct packed {
      logic [ACTIVE_W-1:0] count;
      logic [SCALE_W-1:0]  report;
   } cfg_type;

endpackage

### src/wtd_ifs.sv
// Channel interfaces of the wavelet transient detector.
interface wtd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [wtd_pkg::MODE_W-1:0]             mode;
   logic signed [wtd_pkg::SAMPLE_BITS-1:0] sample;
   logic [wtd_pkg::SCALE_W-1:0]            scale_index;
   logic [wtd_pkg::TAP_W-1:0]              tap_index;
   logic signed [wtd_pkg::COEF_BITS-1:0]   coef_real;
   logic signed [wtd_pkg::COEF_BITS-1:0]   coef_imag;

   modport source (output valid, mode, sample, scale_index, tap_index, coef_real,
                   coef_imag, input ready);
   modport sink (input valid, mode, sample, scale_index, tap_index, coef_real,
                 coef_imag, output ready);
endinterface

interface wtd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wtd_pkg::SCORE_W-1:0]       transient_score;
   logic [wtd_pkg::ENERGY_W-1:0]      selected_energy;

   modport source (output valid, transient_score, selected_energy, input ready);
   modport sink (input valid, transient_score, selected_energy, output ready);
endinterface

interface wtd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wtd_pkg::CSR_IDX_W-1:0]     index;
   logic [wtd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/wtd_front.sv
// Front end: configuration registers and classification of input items.
module wtd_front (
   input  logic              clock,
   input  logic              reset,
   wtd_req_if.sink           req,
   wtd_csr_if.sink           csr,
   input  logic              clearing,
   output wtd_pkg::cmd_type  push_cmd,
   output logic              push_valid,
   input  logic              push_ready,
   output wtd_pkg::cfg_type  cfg
);
   import wtd_pkg::*;

   logic [ACTIVE_W-1:0] active_ff;
   logic [SCALE_W-1:0]  report_ff;
   logic                is_cmd;

   // Register writes are always taken.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         report_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_ACTIVE_SCALES: active_ff <= csr.data;
            CSR_REPORT_SCALE:  report_ff <= csr.data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // The scale count is clamped to the size of the bank.
   assign cfg.count  = (active_ff > ACTIVE_W'(MAX_SCALES)) ? ACTIVE_W'(MAX_SCALES) : active_ff;
   assign cfg.report = report_ff;

   // Decode the mode; an unused mode is accepted and dropped.
   always_comb begin
      push_cmd.kind      = CMD_SAMPLE;
      is_cmd             = 1'b1;
      case (req.mode)
         MODE_SAMPLE: push_cmd.kind = CMD_SAMPLE;
         MODE_LOAD:   push_cmd.kind = CMD_LOAD;
         MODE_CLEAR:  push_cmd.kind = CMD_CLEAR;
         default:     is_cmd = 1'b0;
      endcase
      push_cmd.sample    = req.sample;
      push_cmd.coef_addr = {req.scale_index, req.tap_index};
      push_cmd.coef_real = req.coef_real;
      push_cmd.coef_imag = req.coef_imag;
   end

   assign req.ready  = push_ready & ~clearing;
   assign push_valid = req.valid & ~clearing & is_cmd;

endmodule

### src/wtd_cmd_queue.sv
// Two-entry queue of classified items between the front and the back.
module wtd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  wtd_pkg::cmd_type  push_cmd,
   input  logic              push_valid,
   output logic              push_ready,
   output wtd_pkg::cmd_type  pop_cmd,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import wtd_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] fill_ff;
   logic       push;
   logic       pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         if (push & ~pop) fill_ff <= fill_ff + 2'd1;
         else if (pop & ~push) fill_ff <= fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_cmd;
   end

endmodule

### src/wtd_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module wtd_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [wtd_pkg::NUM_W-1:0]    numerator,
   input  logic [wtd_pkg::DEN_W-1:0]    denominator,
   output logic                         busy,
   output logic [wtd_pkg::NUM_W-1:0]    quotient
);
   import wtd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic             fits;
   logic [DEN_W:0]   diff;

   // Shift in the next numerator bit and try the subtraction.
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   // The numerator register fills up with quotient bits as it empties.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### src/wtd_back.sv
// Back end: history and coefficient memories, complex MAC, energy and score.
module wtd_back (
   input  logic              clock,
   input  logic              reset,
   input  wtd_pkg::cfg_type  cfg,
   input  wtd_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   output logic              clearing,
   wtd_rsp_if.source         rsp
);
   import wtd_pkg::*;

   localparam logic [3:0] ST_WIPE   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MAC    = 4'd2;
   localparam logic [3:0] ST_SQUARE = 4'd3;
   localparam logic [3:0] ST_RISE   = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_NEXT   = 4'd6;
   localparam logic [3:0] ST_MEAN   = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
   localparam logic [SCORE_W-1:0]  SCORE_MAX  = '1;

   // Memories.
   logic signed [SAMPLE_BITS-1:0] hist_mem    [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coef_re_mem [COEF_DEPTH];
   logic signed [COEF_BITS-1:0]   coef_im_mem [COEF_DEPTH];

   // Control registers.
   logic [3:0]             state_ff, state_in;
   logic [COEF_ADDR_W-1:0] wipe_ff, wipe_in;
   logic [TAP_W-1:0]       ptr_ff, ptr_in;
   logic [TAP_W-1:0]       cur_ff, cur_in;
   logic [MAX_TAPS-1:0]    hvld_ff, hvld_in;
   logic [ACTIVE_W-1:0]    scale_ff, scale_in;
   logic [TAP_W:0]         iss_ff, iss_in;
   logic                   s1_v_ff, s1_v_in;
   logic                   s2_v_ff, s2_v_in;
   logic [2:0]             sq_cnt_ff, sq_cnt_in;
   logic                   pv_ff, pv_in;
   logic                   voted_ff, voted_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0]    energy_ff [MAX_SCALES];
   logic [ENERGY_W-1:0]    energy_in [MAX_SCALES];

   // Datapath registers.
   logic signed [SAMPLE_BITS-1:0] h_rd_ff;
   logic signed [COEF_BITS-1:0]   cr_rd_ff;
   logic signed [COEF_BITS-1:0]   ci_rd_ff;
   logic                          hv_rd_ff;
   logic signed [PROD_W-1:0]      pr_ff, pr_in;
   logic signed [PROD_W-1:0]      pi_ff, pi_in;
   logic signed [ACC_W-1:0]       acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]       acc_im_ff, acc_im_in;
   logic [MAG_W-1:0]              mag_re_ff, mag_re_in;
   logic [MAG_W-1:0]              mag_im_ff, mag_im_in;
   logic                          sat_ff, sat_in;
   logic [SQ_W-1:0]               prod_ff, prod_in;
   logic [SQ_W-1:0]               sq_ff, sq_in;
   logic [ENERGY_W-1:0]           e_ff, e_in;
   logic [ENERGY_W-1:0]           sel_ff, sel_in;
   logic [TOTAL_W-1:0]            total_ff, total_in;
   logic [SCORE_W-1:0]            score_ff, score_in;
   logic [SCORE_W-1:0]            rsp_score_ff, rsp_score_in;
   logic [ENERGY_W-1:0]           rsp_energy_ff, rsp_energy_in;

   // Combinational helpers.
   logic [TAP_W-1:0]              h_addr;
   logic [COEF_ADDR_W-1:0]        c_addr;
   logic                          hist_we;
   logic                          coef_we;
   logic [COEF_ADDR_W-1:0]        c_waddr;
   logic signed [COEF_BITS-1:0]   c_wre;
   logic signed [COEF_BITS-1:0]   c_wim;
   logic signed [SAMPLE_BITS-1:0] hx;
   logic [ACC_W-1:0]              abs_re;
   logic [ACC_W-1:0]              abs_im;
   logic [HALF_W-1:0]             op_a;
   logic [HALF_W-1:0]             op_b;
   logic [2*HALF_W-1:0]           sq_mul;
   logic [ENERGY_W-1:0]           prev;
   logic                          div_start;
   logic [NUM_W-1:0]              div_num;
   logic [DEN_W-1:0]              div_den;
   logic                          div_busy;
   logic [NUM_W-1:0]              div_quo;
   logic [ENERGY_W-1:0]           rise;

   wtd_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .busy        (div_busy),
      .quotient    (div_quo)
   );

   // Read addresses of the MAC loop: tap k meets the k-th newest sample.
   assign h_addr = cur_ff - iss_ff[TAP_W-1:0];
   assign c_addr = {scale_ff[SCALE_W-1:0], iss_ff[TAP_W-1:0]};

   // Write ports: the history takes each sample; the coefficients take the clearing pass after reset or a load.
   assign hist_we = (state_ff == ST_IDLE) & cmd_valid & (cmd.kind == CMD_SAMPLE);
   assign coef_we = (state_ff == ST_WIPE) |
                    ((state_ff == ST_IDLE) & cmd_valid & (cmd.kind == CMD_LOAD));
   assign c_waddr = (state_ff == ST_WIPE) ? wipe_ff : cmd.coef_addr;
   assign c_wre   = (state_ff == ST_WIPE) ? '0 : cmd.coef_real;
   assign c_wim   = (state_ff == ST_WIPE) ? '0 : cmd.coef_imag;

   always_ff @(posedge clock) begin
      h_rd_ff  <= hist_mem[h_addr];
      cr_rd_ff <= coef_re_mem[c_addr];
      ci_rd_ff <= coef_im_mem[c_addr];
      if (hist_we) hist_mem[ptr_ff] <= cmd.sample;
      if (coef_we) begin
         coef_re_mem[c_waddr] <= c_wre;
         coef_im_mem[c_waddr] <= c_wim;
      end
   end

   // A history entry not written since the last clear reads as zero.
   assign hx    = hv_rd_ff ? h_rd_ff : '0;
   assign pr_in = hx * cr_rd_ff;
   assign pi_in = hx * ci_rd_ff;

   assign abs_re = acc_re_ff[ACC_W-1] ? ACC_W'(-acc_re_ff) : ACC_W'(acc_re_ff);
   assign abs_im = acc_im_ff[ACC_W-1] ? ACC_W'(-acc_im_ff) : ACC_W'(acc_im_ff);

   // Squares from 18-bit halves: hi*hi, hi*lo and lo*lo for each part.
   always_comb begin
      op_a    = '0;
      op_b    = '0;
      case (sq_cnt_ff)
         3'd0: begin
            op_a = HALF_W'(mag_re_ff[MAG_W-1:HALF_W]);
            op_b = HALF_W'(mag_re_ff[MAG_W-1:HALF_W]);
         end
         3'd1: begin
            op_a = HALF_W'(mag_re_ff[MAG_W-1:HALF_W]);
            op_b = mag_re_ff[HALF_W-1:0];
         end
         3'd2: begin
            op_a = mag_re_ff[HALF_W-1:0];
            op_b = mag_re_ff[HALF_W-1:0];
         end
         3'd3: begin
            op_a = HALF_W'(mag_im_ff[MAG_W-1:HALF_W]);
            op_b = HALF_W'(mag_im_ff[MAG_W-1:HALF_W]);
         end
         3'd4: begin
            op_a = HALF_W'(mag_im_ff[MAG_W-1:HALF_W]);
            op_b = mag_im_ff[HALF_W-1:0];
         end
         3'd5: begin
            op_a = mag_im_ff[HALF_W-1:0];
            op_b = mag_im_ff[HALF_W-1:0];
         end
         default: ;
      endcase
   end

   assign sq_mul = op_a * op_b;

   always_comb begin
      case (sq_cnt_ff)
         3'd0, 3'd3: prod_in = SQ_W'(sq_mul) << (2 * HALF_W);
         3'd1, 3'd4: prod_in = SQ_W'(sq_mul) << (HALF_W + 1);
         default:    prod_in = SQ_W'(sq_mul);
      endcase
   end

   assign prev = energy_ff[scale_ff[SCALE_W-1:0]];
   assign rise = e_ff - prev;

   // Sequencer of the back end.
   always_comb begin
      state_in      = state_ff;
      wipe_in       = wipe_ff;
      ptr_in        = ptr_ff;
      cur_in        = cur_ff;
      hvld_in       = hvld_ff;
      scale_in      = scale_ff;
      iss_in        = iss_ff;
      s1_v_in       = 1'b0;
      s2_v_in       = s1_v_ff;
      sq_cnt_in     = sq_cnt_ff;
      pv_in         = 1'b0;
      voted_in      = voted_ff;
      energy_in     = energy_ff;
      acc_re_in     = acc_re_ff;
      acc_im_in     = acc_im_ff;
      mag_re_in     = mag_re_ff;
      mag_im_in     = mag_im_ff;
      sat_in        = sat_ff;
      sq_in         = sq_ff;
      e_in          = e_ff;
      sel_in        = sel_ff;
      total_in      = total_ff;
      score_in      = score_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      cmd_ready     = 1'b0;

      case (state_ff)
         ST_WIPE: begin
            wipe_in = wipe_ff + COEF_ADDR_W'(1);
            if (wipe_ff == COEF_ADDR_W'(COEF_DEPTH - 1)) state_in = ST_IDLE;
         end

         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_SAMPLE: begin
                     hvld_in[ptr_ff] = 1'b1;
                     cur_in          = ptr_ff;
                     ptr_in          = ptr_ff + TAP_W'(1);
                     scale_in        = '0;
                     iss_in          = '0;
                     voted_in        = 1'b0;
                     total_in        = '0;
                     sel_in          = '0;
                     score_in        = '0;
                     acc_re_in       = '0;
                     acc_im_in       = '0;
                     state_in        = (cfg.count == '0) ? ST_OUT : ST_MAC;
                  end
                  CMD_CLEAR: begin
                     hvld_in = '0;
                     ptr_in  = '0;
                     for (int i = 0; i < MAX_SCALES; i++) energy_in[i] = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_MAC: begin
            s1_v_in = ~iss_ff[TAP_W];
            if (~iss_ff[TAP_W]) iss_in = iss_ff + (TAP_W + 1)'(1);
            if (s2_v_ff) begin
               acc_re_in = acc_re_ff + ACC_W'(pr_ff);
               acc_im_in = acc_im_ff + ACC_W'(pi_ff);
            end
            if (iss_ff[TAP_W] & ~s1_v_ff & ~s2_v_ff) begin
               mag_re_in = abs_re[MAG_W-1:0];
               mag_im_in = abs_im[MAG_W-1:0];
               sat_in    = (|abs_re[ACC_W-1:MAG_W]) | (|abs_im[ACC_W-1:MAG_W]);
               sq_cnt_in = '0;
               sq_in     = '0;
               state_in  = ST_SQUARE;
            end
         end

         ST_SQUARE: begin
            pv_in     = (sq_cnt_ff < 3'd6);
            sq_cnt_in = sq_cnt_ff + 3'd1;
            if (pv_ff) sq_in = sq_ff + prod_ff;
            if (sq_cnt_ff == 3'd7) begin
               e_in     = (sat_ff | (|sq_ff[SQ_W-1:ENERGY_W+28])) ?
                          ENERGY_MAX : sq_ff[ENERGY_W+27:28];
               state_in = ST_RISE;
            end
         end

         ST_RISE: begin
            energy_in[scale_ff[SCALE_W-1:0]] = e_ff;
            if (scale_ff[SCALE_W-1:0] == cfg.report) sel_in = e_ff;
            if (e_ff > prev) begin
               div_start = 1'b1;
               div_num   = {rise, 16'd0};
               div_den   = {1'b0, prev} + EPS_Q;
               voted_in  = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_NEXT;
            end
         end

         ST_DIV: begin
            if (~div_busy) begin
               total_in = total_ff + div_quo[TOTAL_W-1:0];
               state_in = ST_NEXT;
            end
         end

         ST_NEXT: begin
            scale_in = scale_ff + ACTIVE_W'(1);
            iss_in   = '0;
            acc_re_in = '0;
            acc_im_in = '0;
            if (scale_ff + ACTIVE_W'(1) == cfg.count) begin
               if (voted_ff) begin
                  div_start = 1'b1;
                  div_num   = NUM_W'(total_ff);
                  div_den   = DEN_W'(cfg.count);
                  state_in  = ST_MEAN;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               state_in = ST_MAC;
            end
         end

         ST_MEAN: begin
            if (~div_busy) begin
               score_in = (|div_quo[NUM_W-1:SCORE_W]) ? SCORE_MAX : div_quo[SCORE_W-1:0];
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            if (~rsp_valid_ff | rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_score_in  = score_ff;
               rsp_energy_in = sel_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         ptr_ff       <= '0;
         cur_ff       <= '0;
         hvld_ff      <= '0;
         scale_ff     <= '0;
         iss_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         sq_cnt_ff    <= '0;
         pv_ff        <= 1'b0;
         voted_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SCALES; i++) energy_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         ptr_ff       <= ptr_in;
         cur_ff       <= cur_in;
         hvld_ff      <= hvld_in;
         scale_ff     <= scale_in;
         iss_ff       <= iss_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         sq_cnt_ff    <= sq_cnt_in;
         pv_ff        <= pv_in;
         voted_ff     <= voted_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      hv_rd_ff      <= hvld_ff[h_addr];
      pr_ff         <= pr_in;
      pi_ff         <= pi_in;
      acc_re_ff     <= acc_re_in;
      acc_im_ff     <= acc_im_in;
      mag_re_ff     <= mag_re_in;
      mag_im_ff     <= mag_im_in;
      sat_ff        <= sat_in;
      prod_ff       <= prod_in;
      sq_ff         <= sq_in;
      e_ff          <= e_in;
      sel_ff        <= sel_in;
      total_ff      <= total_in;
      score_ff      <= score_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_energy_ff <= rsp_energy_in;
   end

   assign clearing            = (state_ff == ST_WIPE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.transient_score = rsp_score_ff;
   assign rsp.selected_energy = rsp_energy_ff;

endmodule

### src/wavelet_transient_detector_core.sv
// Wavelet transient detector: top level joining front, item queue and back end.
// A sample item is worked through the n active scales in turn; for each scale the single complex
// MAC (one tap a cycle) runs over the taps, and the one-bit-a-cycle divider runs for each
// scale whose energy rose and once more for the mean score when any rose.
// A result waits in an output register while the next item is taken in.
// After reset the coefficient memories are swept to zero, all 2048 addresses in turn, with no item taken.
module wavelet_transient_detector_core (
   input  logic      clock,
   input  logic      reset,
   wtd_req_if.sink   req_ch,
   wtd_rsp_if.source rsp_ch,
   wtd_csr_if.sink   csr_ch
);
   import wtd_pkg::*;

   cmd_type push_cmd;
   logic    push_valid;
   logic    push_ready;
   cmd_type pop_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cfg_type cfg;
   logic    clearing;

   wtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .clearing   (clearing),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .cfg        (cfg)
   );

   wtd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   wtd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (pop_cmd),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .clearing  (clearing),
      .rsp       (rsp_ch)
   );

endmodule
